[rtl/core/ils_pkg.sv]
// Shared constants, codes and types for the indexed list store.
package ils_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int ENTRY_W  = 11;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_HD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_TL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INS_AT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

[rtl/core/ils_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ils_ctrl.sv]
// Sequencer that decodes an item and walks the entry RAM one entry per cycle.
module ils_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [ils_pkg::ACT_W-1:0] action,
  input  logic [ils_pkg::POS_W-1:0] position,
  input  logic [ils_pkg::VAL_W-1:0] item_value,
  output ils_pkg::ram_req_t       ram_req,
  input  logic [ils_pkg::VAL_W-1:0] ram_rdata,
  output logic                    res_valid,
  input  logic                    res_ok,
  output ils_pkg::result_t        res
);

  import ils_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_UP, S_DOWN, S_FILL, S_REPLY} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] cur;
  logic [ADDR_W-1:0] last;
  logic [ADDR_W-1:0] wr;
  logic              more;
  logic              rvalid;
  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  rv;
  logic [STAT_W-1:0] st;

  logic             fire;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] p_w;
  logic             is_ins;
  logic             full;

  assign req_ready = (state == S_IDLE);
  assign fire      = req_valid && req_ready;
  assign pos_w     = CMP_W'(position);
  assign cnt_w     = CMP_W'(count);
  assign full      = (count == CNT_W'(CAPACITY));
  assign is_ins    = (action == ACT_INS_HD) || (action == ACT_INS_TL) ||
                     (action == ACT_INS_AT);

  always_comb begin
    case (action)
      ACT_INS_HD: p_w = '0;
      ACT_INS_TL: p_w = cnt_w;
      default:    p_w = pos_w;
    endcase
  end

  // RAM port control. A shift reads one entry ahead of the write it feeds.
  always_comb begin
    ram_req = '0;
    case (state)
      S_IDLE: begin
        if (fire && action == ACT_READ && pos_w < cnt_w) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ADDR_W'(position);
        end
        if (fire && is_ins && !full && p_w == cnt_w) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = ADDR_W'(count);
          ram_req.wdata = item_value;
        end
      end
      S_UP, S_DOWN: begin
        ram_req.re    = more;
        ram_req.raddr = cur;
        ram_req.we    = rvalid;
        ram_req.waddr = wr;
        ram_req.wdata = ram_rdata;
      end
      S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = last;
        ram_req.wdata = val;
      end
      default: ;
    endcase
  end

  assign res_valid       = (state == S_REPLY);
  assign res.read_value  = rv;
  assign res.status      = st;
  assign res.entry_count = ENTRY_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      more   <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fire) begin
            rv <= '0;
            st <= ST_DONE;
            state <= S_REPLY;
            if (action == ACT_READ) begin
              if (pos_w < cnt_w) begin
                state <= S_READ;
              end else begin
                rv <= '1;
                st <= ST_RANGE;
              end
            end else if (is_ins) begin
              // The range test comes before the full test.
              if (action == ACT_INS_AT && pos_w > cnt_w) begin
                st <= ST_RANGE;
              end else if (full) begin
                st <= ST_FULL;
              end else begin
                count <= count + 1'b1;
                if (p_w != cnt_w) begin
                  cur    <= ADDR_W'(count - 1'b1);
                  last   <= ADDR_W'(p_w);
                  val    <= item_value;
                  more   <= 1'b1;
                  rvalid <= 1'b0;
                  state  <= S_UP;
                end
              end
            end else if (action == ACT_DELETE) begin
              if (pos_w < cnt_w) begin
                count <= count - 1'b1;
                if (pos_w + 1'b1 < cnt_w) begin
                  cur    <= ADDR_W'(pos_w + 1'b1);
                  last   <= ADDR_W'(count - 1'b1);
                  more   <= 1'b1;
                  rvalid <= 1'b0;
                  state  <= S_DOWN;
                end
              end else begin
                st <= ST_RANGE;
              end
            end
          end
        end
        S_READ: begin
          rv    <= ram_rdata;
          state <= S_REPLY;
        end
        S_UP: begin
          rvalid <= more;
          if (more) begin
            wr <= cur + 1'b1;
            if (cur == last) begin
              more <= 1'b0;
            end else begin
              cur <= cur - 1'b1;
            end
          end else if (rvalid) begin
            state <= S_FILL;
          end
        end
        S_DOWN: begin
          rvalid <= more;
          if (more) begin
            wr <= cur - 1'b1;
            if (cur == last) begin
              more <= 1'b0;
            end else begin
              cur <= cur + 1'b1;
            end
          end else if (rvalid) begin
            state <= S_REPLY;
          end
        end
        S_FILL: begin
          state <= S_REPLY;
        end
        S_REPLY: begin
          if (res_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/indexed_list_store.sv]
// Indexed list store: an ordered list of signed 32-bit values kept in one RAM.
// A read passes through a RAM read state before its reply; an item that moves no entries
// goes straight to its reply; an insert shifts entries up and then fills its slot, and a delete
// shifts entries down, since the single read and write port moves one entry per cycle.
// One item is in work at a time; the next is taken the cycle after its result loads.
// Reset clears the entry count and the handshake state; the RAM is not cleared.
module indexed_list_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [ils_pkg::ACT_W-1:0]   action,
  input  logic [ils_pkg::POS_W-1:0]   position,
  input  logic [ils_pkg::VAL_W-1:0]   item_value,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [ils_pkg::VAL_W-1:0]   read_value,
  output logic [ils_pkg::STAT_W-1:0]  status,
  output logic [ils_pkg::ENTRY_W-1:0] entry_count
);

  import ils_pkg::*;

  logic     req_ready;
  ram_req_t ram_req;
  logic [VAL_W-1:0] ram_rdata;
  logic     res_valid;
  logic     res_ok;
  result_t  res;

  assign req_stall = !req_ready;
  assign res_ok    = !rsp_valid || !rsp_stall;

  ils_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .action     (action),
    .position   (position),
    .item_value (item_value),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ok     (res_ok),
    .res        (res)
  );

  ils_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output register keeps a finished result while the sequencer takes the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ok) begin
      rsp_valid <= res_valid;
    end
    if (res_ok && res_valid) begin
      read_value  <= res.read_value;
      status      <= res.status;
      entry_count <= res.entry_count;
    end
  end

endmodule

[rtl/core/ils_check.sv]
// Port-level checker for the indexed list store, bound to the top level.
module ils_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [ils_pkg::VAL_W-1:0]   read_value,
  input logic [ils_pkg::STAT_W-1:0]  status,
  input logic [ils_pkg::ENTRY_W-1:0] entry_count
);

  import ils_pkg::*;

  // A stalled result holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(status) &&
      $stable(entry_count))
    else $error("stalled result changed");

  // Only one item is in work: the cycle after acceptance the input is stalled.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item accepted back to back");

  // A full status is only reported when the store holds CAPACITY entries.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == ENTRY_W'(CAPACITY))
    else $error("full status with room left");

  // A refused insert reports a zero value.
  a_full_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> read_value == '0)
    else $error("refused insert returned a value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == ST_DONE || status == ST_RANGE || status == ST_FULL)
    else $error("unknown status code");

endmodule

bind indexed_list_store ils_check u_ils_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .read_value  (read_value),
  .status      (status),
  .entry_count (entry_count)
);

[tb/sv/tb.sv]
// Self-checking testbench for the indexed list store: directed table and random traffic.
module tb;
  import ils_pkg::*;

  // Action codes the block leaves unused.
  localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_MID   = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  localparam int DIR_N        = 25;
  localparam int PHASE_ITEMS  = 185;
  localparam int LONG_HOLD    = 80;
  localparam int STALL_LIMIT  = 16 * CAPACITY;
  localparam int TAIL_CYCLES  = CAPACITY + 8;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    result_t          want;
  } step_row_t;

  localparam step_row_t DIRECTED [DIR_N] = '{
    '{ACT_READ,         16'h0000, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_RANGE, 11'd0}},
    '{ACT_DELETE,       16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_RANGE, 11'd0}},
    '{ACT_INS_AT,       16'h0001, 32'h0000_0005, 1'b1, '{32'h0000_0000, ST_RANGE, 11'd0}},
    '{ACT_INS_AT,       16'hFFFF, 32'h0000_0007, 1'b1, '{32'h0000_0000, ST_RANGE, 11'd0}},
    '{ACT_READ,         16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, ST_RANGE, 11'd0}},
    '{ACT_INS_AT,       16'h0000, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_DONE,  11'd1}},
    '{ACT_INS_HD,       16'hFFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_DONE,  11'd2}},
    '{ACT_INS_TL,       16'h0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_DONE,  11'd3}},
    '{ACT_INS_AT,       16'h0003, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_DONE,  11'd4}},
    '{ACT_READ,         16'h0000, 32'h1234_5678, 1'b1, '{32'h8000_0000, ST_DONE,  11'd4}},
    '{ACT_READ,         16'h0001, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_DONE,  11'd4}},
    '{ACT_READ,         16'h0003, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_DONE,  11'd4}},
    '{ACT_READ,         16'h0004, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_RANGE, 11'd4}},
    '{ACT_INS_AT,       16'h0005, 32'h0BAD_F00D, 1'b1, '{32'h0000_0000, ST_RANGE, 11'd4}},
    '{ACT_INS_AT,       16'h0002, 32'hA5A5_5A5A, 1'b0, '0},
    '{ACT_READ,         16'h0002, 32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE,       16'h0005, 32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE,       16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE,       16'h0003, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_READ,         16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_UNUSED_FIRST, 16'h1234, 32'hDEAD_BEEF, 1'b0, '0},
    '{ACT_UNUSED_MID,   16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_UNUSED_LAST,  16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_DELETE,       16'hFFFF, 32'h0000_0000, 1'b0, '0},
    '{ACT_READ,         16'h0002, 32'h0000_0000, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [ACT_W-1:0]   action = '0;
  logic [POS_W-1:0]   position = '0;
  logic [VAL_W-1:0]   item_value = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [VAL_W-1:0]   read_value;
  logic [STAT_W-1:0]  status;
  logic [ENTRY_W-1:0] entry_count;

  indexed_list_store dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the list, updated as each item is accepted.
  logic [VAL_W-1:0] shadow_entries [CAPACITY];
  int               shadow_count = 0;
  result_t          pending_results [$];

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int peak_count    = 0;
  int full_refusals = 0;
  int range_reports = 0;

  int sender_idle_pct = 11;
  int rcv_idle_pct    = 45;
  int hold_req_seq    = 0;
  int hold_seen_seq   = 0;
  int hold_left       = 0;

  function automatic logic [STAT_W-1:0] place_entry(int at, logic [VAL_W-1:0] v);
    if (shadow_count >= CAPACITY) return ST_FULL;
    if (at > shadow_count) return ST_RANGE;
    for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[at] = v;
    shadow_count++;
    return ST_DONE;
  endfunction

  function automatic result_t apply_list_action(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                                logic [VAL_W-1:0] val);
    result_t r;
    int      p;
    r.read_value = '0;
    r.status     = ST_DONE;
    p = pos;
    case (act)
      ACT_READ: begin
        if (p < shadow_count) begin
          r.read_value = shadow_entries[p];
        end else begin
          r.read_value = '1;
          r.status     = ST_RANGE;
        end
      end
      ACT_INS_HD: r.status = place_entry(0, val);
      ACT_INS_TL: r.status = place_entry(shadow_count, val);
      ACT_INS_AT: begin
        // The range test wins over the full test for an insert at an index.
        if (p > shadow_count) r.status = ST_RANGE;
        else r.status = place_entry(p, val);
      end
      ACT_DELETE: begin
        if (p < shadow_count) begin
          for (int i = p; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.entry_count = ENTRY_W'(shadow_count);
    return r;
  endfunction

  // Offers one item, holds it until accepted and records what it should produce.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic typed, input result_t want);
    result_t predicted;
    int      gap;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    action     <= act;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (!(req_valid && !req_stall));
    predicted = apply_list_action(act, pos, val);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (predicted.status == ST_FULL) full_refusals++;
    if (predicted.status == ST_RANGE) range_reports++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly legal actions with random content; the rest is arbitrary noise.
  task automatic pick_random_item(output logic [ACT_W-1:0] act, output logic [POS_W-1:0] pos,
                                  output logic [VAL_W-1:0] val);
    int choice;
    choice = $urandom_range(15);
    case (choice)
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'hFFFF_FFFF;
      3:       val = 32'h0000_0000;
      default: val = $urandom;
    endcase
    if ($urandom_range(99) < 20) begin
      act = ACT_W'($urandom_range(7));
      case ($urandom_range(3))
        0:       pos = POS_W'($urandom);
        1:       pos = POS_W'(shadow_count);
        2:       pos = POS_W'(shadow_count + 1);
        default: pos = POS_W'($urandom_range(shadow_count));
      endcase
    end else begin
      choice = $urandom_range(4);
      if (shadow_count == 0) choice = $urandom_range(1, 3);
      else if (shadow_count > 40 && choice >= 1 && choice <= 3 && $urandom_range(1) == 1)
        choice = 4;
      pos = POS_W'($urandom);
      case (choice)
        0: begin
          act = ACT_READ;
          pos = POS_W'($urandom_range(shadow_count - 1));
        end
        1: act = ACT_INS_HD;
        2: act = ACT_INS_TL;
        3: begin
          act = ACT_INS_AT;
          pos = POS_W'($urandom_range(shadow_count));
        end
        default: begin
          act = ACT_DELETE;
          pos = POS_W'($urandom_range(shadow_count - 1));
        end
      endcase
    end
  endtask

  task automatic check_field(input string label, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t oldest;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result read_value %h status %h entry_count %0d",
                 $time, read_value, status, entry_count);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("read_value", oldest.read_value, read_value);
        check_field("status", VAL_W'(oldest.status), VAL_W'(status));
        check_field("entry_count", VAL_W'(oldest.entry_count), VAL_W'(entry_count));
      end
    end
  end

  // Result side: random stall, or a long hold-off when the sender asks for one.
  always @(posedge clk) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq <= hold_req_seq;
      hold_left     <= LONG_HOLD;
      rsp_stall     <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               saved_idle;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].act, DIRECTED[i].pos, DIRECTED[i].val,
                DIRECTED[i].typed, DIRECTED[i].want);
    drain_results();

    saved_idle = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 11; rcv_idle_pct = 45; end
        1: begin sender_idle_pct = 45; rcv_idle_pct = 11; end
        default: begin sender_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Stop taking results for a while and keep offering items so the block backs up.
        if (phase == 0 && n == 60) begin
          hold_req_seq   <= hold_req_seq + 1;
          saved_idle      = sender_idle_pct;
          sender_idle_pct = 0;
        end
        if (phase == 0 && n == 72) sender_idle_pct = saved_idle;
        pick_random_item(act, pos, val);
        send_item(act, pos, val, 1'b0, '0);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d items and %0d results, peak list length %0d,",
             items_sent, results_seen, peak_count);
    $display("with %0d full refusals and %0d out-of-range reports.", full_refusals, range_reports);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
